/* hw/rtl/strain_from_node_gradients_macros.svh */
// Assertion macros for the checker file sfng_chk.sv.
`ifndef STRAIN_FROM_NODE_GRADIENTS_MACROS_SVH
`define STRAIN_FROM_NODE_GRADIENTS_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define SFNG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfng check failed");

// Next-cycle implication, quiet while in reset
`define SFNG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfng check failed");

// Next-cycle implication, also checked through reset
`define SFNG_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfng check failed");

`endif

/* hw/rtl/sfng_pkg.sv */
package sfng_pkg;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned ACC_W = 64;

  typedef logic signed [IN_W-1:0]  q16_t;
  typedef logic signed [ACC_W-1:0] q32_t;

  localparam q32_t SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam q32_t SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One node's six strain terms, with the end-of-point mark
  typedef struct packed {
    q32_t xx;
    q32_t yy;
    q32_t zz;
    q32_t xy;
    q32_t yz;
    q32_t xz;
    logic last;
  } term_t;

  // Add with clamp to the signed 64-bit range
  function automatic q32_t sat_add(input q32_t a, input q32_t b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? SAT_MIN : SAT_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

/* hw/rtl/sfng_front.sv */
module sfng_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfng_pkg::q16_t        in_grad_x,
  input  sfng_pkg::q16_t        in_grad_y,
  input  sfng_pkg::q16_t        in_grad_z,
  input  sfng_pkg::q16_t        in_disp_x,
  input  sfng_pkg::q16_t        in_disp_y,
  input  sfng_pkg::q16_t        in_disp_z,
  input  logic                  in_last_node,
  output logic                  push_valid,
  input  logic                  push_ready,
  output sfng_pkg::term_t       push_data
);

  // Stage 1: nine products
  logic           s1_v_r, s1_v_nxt;
  logic           s1_last_r;
  sfng_pkg::q32_t p_xx_r, p_yy_r, p_zz_r;
  sfng_pkg::q32_t p_yx_r, p_xy_r, p_zy_r, p_yz_r, p_zx_r, p_xz_r;

  // Stage 2: pair sums, ready for the queue
  logic            s2_v_r, s2_v_nxt;
  sfng_pkg::term_t s2_r, s2_nxt;

  logic s1_adv, s2_adv;

  assign s2_adv   = !s2_v_r || push_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  assign s1_v_nxt = s1_adv ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_adv ? s1_v_r : s2_v_r;

  // Combine shear pairs with clamp
  always_comb begin
    s2_nxt.xx   = p_xx_r;
    s2_nxt.yy   = p_yy_r;
    s2_nxt.zz   = p_zz_r;
    s2_nxt.xy   = sfng_pkg::sat_add(p_yx_r, p_xy_r);
    s2_nxt.yz   = sfng_pkg::sat_add(p_zy_r, p_yz_r);
    s2_nxt.xz   = sfng_pkg::sat_add(p_zx_r, p_xz_r);
    s2_nxt.last = s1_last_r;
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Load products on accept
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      p_xx_r    <= in_grad_x * in_disp_x;
      p_yy_r    <= in_grad_y * in_disp_y;
      p_zz_r    <= in_grad_z * in_disp_z;
      p_yx_r    <= in_grad_y * in_disp_x;
      p_xy_r    <= in_grad_x * in_disp_y;
      p_zy_r    <= in_grad_z * in_disp_y;
      p_yz_r    <= in_grad_y * in_disp_z;
      p_zx_r    <= in_grad_z * in_disp_x;
      p_xz_r    <= in_grad_x * in_disp_z;
      s1_last_r <= in_last_node;
    end
  end

  // Load pair sums
  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign push_valid = s2_v_r;
  assign push_data  = s2_r;

endmodule

/* hw/rtl/sfng_queue.sv */
module sfng_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  sfng_pkg::term_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sfng_pkg::term_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfng_pkg::term_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign pop_valid  = (count_r != '0);
  assign do_pop     = pop_valid && pop_ready;
  // A full queue still takes an item in the cycle one leaves
  assign push_ready = (count_r != CNT_FULL) || do_pop;
  assign do_push    = push_valid && push_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/sfng_back.sv */
module sfng_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sfng_pkg::term_t pop_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sfng_pkg::q32_t  out_strain_xx,
  output sfng_pkg::q32_t  out_strain_yy,
  output sfng_pkg::q32_t  out_strain_zz,
  output sfng_pkg::q32_t  out_shear_xy,
  output sfng_pkg::q32_t  out_shear_yz,
  output sfng_pkg::q32_t  out_shear_xz
);

  sfng_pkg::q32_t acc_xx_r, acc_yy_r, acc_zz_r, acc_xy_r, acc_yz_r, acc_xz_r;
  sfng_pkg::q32_t sum_xx, sum_yy, sum_zz, sum_xy, sum_yz, sum_xz;
  sfng_pkg::q32_t res_xx_r, res_yy_r, res_zz_r, res_xy_r, res_yz_r, res_xz_r;
  logic           out_valid_r, out_valid_nxt;
  logic           fire, fire_last;

  // A last item waits only while the output register is still occupied
  assign pop_ready = !pop_data.last || !out_valid_r || out_ready;
  assign fire      = pop_valid && pop_ready;
  assign fire_last = fire && pop_data.last;

  assign sum_xx = sfng_pkg::sat_add(acc_xx_r, pop_data.xx);
  assign sum_yy = sfng_pkg::sat_add(acc_yy_r, pop_data.yy);
  assign sum_zz = sfng_pkg::sat_add(acc_zz_r, pop_data.zz);
  assign sum_xy = sfng_pkg::sat_add(acc_xy_r, pop_data.xy);
  assign sum_yz = sfng_pkg::sat_add(acc_yz_r, pop_data.yz);
  assign sum_xz = sfng_pkg::sat_add(acc_xz_r, pop_data.xz);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Accumulate; clear after the last node of a point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_xx_r    <= '0;
      acc_yy_r    <= '0;
      acc_zz_r    <= '0;
      acc_xy_r    <= '0;
      acc_yz_r    <= '0;
      acc_xz_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire_last) begin
        acc_xx_r <= '0;
        acc_yy_r <= '0;
        acc_zz_r <= '0;
        acc_xy_r <= '0;
        acc_yz_r <= '0;
        acc_xz_r <= '0;
      end else if (fire) begin
        acc_xx_r <= sum_xx;
        acc_yy_r <= sum_yy;
        acc_zz_r <= sum_zz;
        acc_xy_r <= sum_xy;
        acc_yz_r <= sum_yz;
        acc_xz_r <= sum_xz;
      end
    end
  end

  // Capture the finished point
  always_ff @(posedge clk) begin
    if (fire_last) begin
      res_xx_r <= sum_xx;
      res_yy_r <= sum_yy;
      res_zz_r <= sum_zz;
      res_xy_r <= sum_xy;
      res_yz_r <= sum_yz;
      res_xz_r <= sum_xz;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_strain_xx = res_xx_r;
  assign out_strain_yy = res_yy_r;
  assign out_strain_zz = res_zz_r;
  assign out_shear_xy  = res_xy_r;
  assign out_shear_yz  = res_yz_r;
  assign out_shear_xz  = res_xz_r;

endmodule

/* hw/rtl/strain_from_node_gradients.sv */
// Channel   Handshake              Payload
// in_       in_valid / in_ready    grad_x/y/z, disp_x/y/z (Q16.16), last_node
// out_      out_valid / out_ready  strain_xx/yy/zz, shear_xy/yz/xz (Q32.32)
//
// Takes one node item per cycle while in_ready is high; nine 32x32 products
// are registered, shear pairs summed in a second stage, then the item enters
// a DEPTH-entry queue, and a result passes the product, pair-sum, queue and
// result registers. Synchronous active-low reset clears accumulators, queue
// and valid flags. The accumulator stage takes one item per cycle from the
// queue; a stalled output holds only last-node items, others keep flowing.
module strain_from_node_gradients #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_grad_x,
  input  logic signed [31:0]    in_grad_y,
  input  logic signed [31:0]    in_grad_z,
  input  logic signed [31:0]    in_disp_x,
  input  logic signed [31:0]    in_disp_y,
  input  logic signed [31:0]    in_disp_z,
  input  logic                  in_last_node,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [63:0]    out_strain_xx,
  output logic signed [63:0]    out_strain_yy,
  output logic signed [63:0]    out_strain_zz,
  output logic signed [63:0]    out_shear_xy,
  output logic signed [63:0]    out_shear_yz,
  output logic signed [63:0]    out_shear_xz
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  sfng_pkg::term_t push_data, pop_data;

  sfng_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_grad_x    (in_grad_x),
    .in_grad_y    (in_grad_y),
    .in_grad_z    (in_grad_z),
    .in_disp_x    (in_disp_x),
    .in_disp_y    (in_disp_y),
    .in_disp_z    (in_disp_z),
    .in_last_node (in_last_node),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  sfng_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sfng_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_strain_xx (out_strain_xx),
    .out_strain_yy (out_strain_yy),
    .out_strain_zz (out_strain_zz),
    .out_shear_xy  (out_shear_xy),
    .out_shear_yz  (out_shear_yz),
    .out_shear_xz  (out_shear_xz)
  );

endmodule

/* hw/rtl/sfng_chk.sv */
`include "strain_from_node_gradients_macros.svh"

module sfng_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_strain_xx,
  input logic signed [63:0] out_strain_yy,
  input logic signed [63:0] out_strain_zz,
  input logic signed [63:0] out_shear_xy,
  input logic signed [63:0] out_shear_yz,
  input logic signed [63:0] out_shear_xz
);

  logic [383:0] out_all;

  // Gather the result fields for the stability check
  assign out_all = {out_strain_xx, out_strain_yy, out_strain_zz,
                    out_shear_xy, out_shear_yz, out_shear_xz};

  // No result straight out of reset
  `SFNG_ASSERT_NXT_ALL(a_reset_quiet, !rst_n, !out_valid)

  // A draining output never throttles the input
  `SFNG_ASSERT_IMP(a_drain_no_stall, out_ready, in_ready)

  // A stalled result stays offered
  `SFNG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its values
  `SFNG_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_all))

endmodule

bind strain_from_node_gradients sfng_chk u_chk (.*);
